@@ src/cspp_pkg.sv @@
package cspp_pkg;
  localparam int SIGNALS_DEF = 64;
  localparam int PDUS_DEF = 16;
  localparam int PDU_BYTES_DEF = 8;

  typedef enum logic [2:0] {
    OP_LOAD_SIG = 3'd0,
    OP_LOAD_PDU = 3'd1,
    OP_SEND = 3'd2,
    OP_RECV = 3'd3,
    OP_RX_PDU = 3'd4,
    OP_TICK = 3'd5
  } op_t;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_SIGS = 2'd1;
  localparam logic [1:0] REG_PDUS = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] signal_index;
    logic [3:0] pdu_index;
    logic [5:0] bit_position;
    logic [6:0] bit_size;
    logic triggered;
    logic is_tx;
    logic [15:0] period;
    logic [3:0] byte_count;
    logic [63:0] data;
    logic err;
  } cmd_t;

  function automatic logic [63:0] low_bits(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) m = '1;
    else m = (64'd1 << n[5:0]) - 64'd1;
    return m;
  endfunction
endpackage

@@ src/cspp_ram.sv @@
module cspp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/cspp_front.sv @@
module cspp_front import cspp_pkg::*; (
  input  logic in_start,
  output logic in_busy,
  input  logic [2:0] in_operation,
  input  logic [5:0] in_signal_index,
  input  logic [3:0] in_pdu_index,
  input  logic [5:0] in_bit_position,
  input  logic [6:0] in_bit_size,
  input  logic in_triggered,
  input  logic in_is_tx,
  input  logic [15:0] in_period,
  input  logic [3:0] in_byte_count,
  input  logic [63:0] in_data,
  input  logic en,
  input  logic [6:0] sig_lim,
  input  logic [4:0] pdu_lim,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_cmd
);
  logic bad;
  always_comb begin
    bad = !en || in_operation > OP_TICK;
    if ((in_operation == OP_LOAD_SIG || in_operation == OP_SEND || in_operation == OP_RECV)
        && {1'b0, in_signal_index} >= sig_lim) bad = 1'b1;
    if ((in_operation == OP_LOAD_SIG || in_operation == OP_LOAD_PDU ||
         in_operation == OP_RX_PDU) && {1'b0, in_pdu_index} >= pdu_lim) bad = 1'b1;
  end
  assign in_busy = q_full;
  assign q_push = in_start && !q_full;
  assign q_cmd = '{op: in_operation, signal_index: in_signal_index,
                   pdu_index: in_pdu_index, bit_position: in_bit_position,
                   bit_size: in_bit_size, triggered: in_triggered, is_tx: in_is_tx,
                   period: in_period, byte_count: in_byte_count, data: in_data, err: bad};
endmodule

@@ src/cspp_back.sv @@
module cspp_back import cspp_pkg::*; #(
  parameter int SIGNALS = SIGNALS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  input  logic [4:0] pdu_lim,
  output logic out_strobe,
  output logic out_kind,
  output logic out_status,
  output logic [63:0] out_result_value,
  output logic [3:0] out_tx_pdu,
  output logic [3:0] out_tx_length,
  output logic out_last,
  output logic idle
);
  localparam int SW = $clog2(SIGNALS);
  typedef enum logic [3:0] {S_IDLE = 4'b0001, S_LOOK = 4'b0010, S_EXEC = 4'b0100,
                            S_TICK = 4'b1000} st_t;
  st_t st_r, st_nxt;
  cmd_t c_r;
  logic [63:0] bytes_r [16];
  logic [3:0] len_r [16];
  logic [15:0] per_r [16], cnt_r [16];
  logic [15:0] tx_r, pend_r;
  logic [3:0] ti_r;
  logic any_r;
  logic [15:0] will_r, will_nxt;
  logic later;
  logic [17:0] sig_rd;
  logic sig_we;
  logic [6:0] sz;
  logic [3:0] sp;
  logic [5:0] spos;
  logic [63:0] fm, w;
  logic [3:0] nb;
  logic tpend, tfire;
  logic [15:0] cinc;

  assign sz = (q_cmd.bit_size > 7'd64) ? 7'd64 : q_cmd.bit_size;
  assign sig_we = q_pop && q_cmd.op == OP_LOAD_SIG && !q_cmd.err;
  cspp_ram #(.WIDTH(18), .DEPTH(SIGNALS)) u_sig (
    .clk(clk), .we(sig_we), .waddr(q_cmd.signal_index[SW-1:0]),
    .wdata({q_cmd.pdu_index, q_cmd.bit_position, sz, q_cmd.triggered}),
    .raddr(q_cmd.signal_index[SW-1:0]), .rdata(sig_rd));
  assign sp = sig_rd[17:14];
  assign spos = sig_rd[13:8];
  assign fm = low_bits(sig_rd[7:1]);
  assign w = bytes_r[sp];
  assign nb = (c_r.byte_count > 4'(PDU_BYTES_DEF)) ? 4'(PDU_BYTES_DEF) : c_r.byte_count;
  assign cinc = cnt_r[ti_r] + 16'd1;
  assign tfire = tx_r[ti_r] && per_r[ti_r] != 16'd0 && cinc >= per_r[ti_r];
  assign tpend = tx_r[ti_r] && (pend_r[ti_r] || tfire);
  assign later = |((will_r >> ti_r) >> 1);
  assign q_pop = st_r == S_IDLE && q_valid;
  assign idle = st_r == S_IDLE;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      will_nxt[i] = tx_r[i] && (5'(i) < pdu_lim) &&
                    (pend_r[i] || (per_r[i] != 16'd0 && cnt_r[i] + 16'd1 >= per_r[i]));
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) begin
        if (q_cmd.err || q_cmd.op == OP_LOAD_SIG) st_nxt = S_IDLE;
        else if (q_cmd.op == OP_SEND || q_cmd.op == OP_RECV) st_nxt = S_LOOK;
        else if (q_cmd.op == OP_TICK) st_nxt = (pdu_lim == 5'd0) ? S_IDLE : S_TICK;
        else st_nxt = S_EXEC;
      end
      S_LOOK: st_nxt = S_IDLE;
      S_EXEC: st_nxt = S_IDLE;
      S_TICK: if ({1'b0, ti_r} + 5'd1 >= pdu_lim) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_strobe <= 1'b0;
      tx_r <= '0;
      pend_r <= '0;
      for (int i = 0; i < 16; i++) begin
        bytes_r[i] <= '0; len_r[i] <= '0; per_r[i] <= '0; cnt_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      out_strobe <= 1'b0;
      out_kind <= 1'b0; out_status <= 1'b0; out_result_value <= '0;
      out_tx_pdu <= '0; out_tx_length <= '0; out_last <= 1'b1;
      case (st_r)
        S_IDLE: if (q_valid) begin
          c_r <= q_cmd;
          ti_r <= '0;
          any_r <= 1'b0;
          will_r <= will_nxt;
          if (q_cmd.err || q_cmd.op == OP_LOAD_SIG || (q_cmd.op == OP_TICK && pdu_lim == 5'd0))
          begin
            out_strobe <= 1'b1;
            out_status <= q_cmd.err;
          end
        end
        S_LOOK: begin
          out_strobe <= 1'b1;
          if ({1'b0, sp} >= pdu_lim) out_status <= 1'b1;
          else if (c_r.op == OP_SEND) begin
            bytes_r[sp] <= (w & ~(fm << spos)) | ((c_r.data & fm) << spos);
            if (sig_rd[0]) pend_r[sp] <= 1'b1;
          end else out_result_value <= (w >> spos) & fm;
        end
        S_EXEC: begin
          out_strobe <= 1'b1;
          len_r[c_r.pdu_index] <= nb;
          if (c_r.op == OP_LOAD_PDU) begin
            per_r[c_r.pdu_index] <= c_r.period;
            tx_r[c_r.pdu_index] <= c_r.is_tx;
            bytes_r[c_r.pdu_index] <= '0;
            pend_r[c_r.pdu_index] <= 1'b0;
            cnt_r[c_r.pdu_index] <= '0;
          end else bytes_r[c_r.pdu_index] <= (bytes_r[c_r.pdu_index] & ~low_bits({nb, 3'b0}))
                                             | (c_r.data & low_bits({nb, 3'b0}));
        end
        S_TICK: begin
          ti_r <= ti_r + 4'd1;
          if (tx_r[ti_r] && per_r[ti_r] != 16'd0) cnt_r[ti_r] <= tfire ? 16'd0 : cinc;
          if (tpend) begin
            pend_r[ti_r] <= 1'b0;
            any_r <= 1'b1;
          end
          if (tpend || (st_nxt == S_IDLE && !any_r)) begin
            out_strobe <= 1'b1;
            out_kind <= tpend;
            out_result_value <= tpend ? bytes_r[ti_r] : '0;
            out_tx_pdu <= tpend ? ti_r : '0;
            out_tx_length <= tpend ? len_r[ti_r] : '0;
            out_last <= !later;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ src/can_signal_pdu_packer_unit.sv @@
// Channel   Handshake           Payload
// input     in_start / in_busy  in_operation .. in_data
// result    out_strobe          out_kind .. out_last
// config    APB psel/penable    paddr, pwdata, prdata
// Signal loads, errors and ticks with no PDUs in use are answered from the idle state;
// send/receive wait on the signal table RAM read; ticks walk PDUs one a cycle.
// A two-entry command queue lets new beats enter while the back end works.
// Reset is synchronous; results are never stalled by the receiver.
module can_signal_pdu_packer_unit import cspp_pkg::*; #(
  parameter int SIGNALS = SIGNALS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_start,
  output logic in_busy,
  input  logic [2:0] in_operation,
  input  logic [5:0] in_signal_index,
  input  logic [3:0] in_pdu_index,
  input  logic [5:0] in_bit_position,
  input  logic [6:0] in_bit_size,
  input  logic in_triggered,
  input  logic in_is_tx,
  input  logic [15:0] in_period,
  input  logic [3:0] in_byte_count,
  input  logic [63:0] in_data,
  output logic out_strobe,
  output logic out_kind,
  output logic out_status,
  output logic [63:0] out_result_value,
  output logic [3:0] out_tx_pdu,
  output logic [3:0] out_tx_length,
  output logic out_last,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic en_r;
  logic [6:0] sigs_r;
  logic [4:0] pdus_r;
  logic [6:0] sig_lim;
  logic [4:0] pdu_lim;
  cmd_t qm_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic push, pop, idle;
  cmd_t pc;

  assign pready = 1'b1;
  assign sig_lim = (sigs_r > 7'(SIGNALS)) ? 7'(SIGNALS) : sigs_r;
  assign pdu_lim = (pdus_r > 5'(PDUS_DEF)) ? 5'(PDUS_DEF) : pdus_r;
  always_comb begin
    case (paddr[3:2])
      REG_ENABLE: prdata = {31'd0, en_r};
      REG_SIGS: prdata = {25'd0, sigs_r};
      REG_PDUS: prdata = {27'd0, pdus_r};
      default: prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0; sigs_r <= '0; pdus_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ENABLE: en_r <= pwdata[0];
        REG_SIGS: sigs_r <= pwdata[6:0];
        REG_PDUS: pdus_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  cspp_front u_front (
    .in_start(in_start), .in_busy(in_busy),
    .in_operation(in_operation), .in_signal_index(in_signal_index),
    .in_pdu_index(in_pdu_index), .in_bit_position(in_bit_position),
    .in_bit_size(in_bit_size), .in_triggered(in_triggered), .in_is_tx(in_is_tx),
    .in_period(in_period), .in_byte_count(in_byte_count), .in_data(in_data),
    .en(en_r), .sig_lim(sig_lim), .pdu_lim(pdu_lim), .q_full(cnt_r == 2'd2),
    .q_push(push), .q_cmd(pc));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) begin
        qm_r[wp_r] <= pc;
        wp_r <= !wp_r;
      end
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  cspp_back #(.SIGNALS(SIGNALS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(cnt_r != 2'd0), .q_cmd(qm_r[rp_r]), .q_pop(pop),
    .pdu_lim(pdu_lim), .out_strobe(out_strobe), .out_kind(out_kind),
    .out_status(out_status), .out_result_value(out_result_value),
    .out_tx_pdu(out_tx_pdu), .out_tx_length(out_tx_length), .out_last(out_last),
    .idle(idle));

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("queue underflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> idle) else $error("pop while busy");
endmodule
